// ===== rtl/clms_pkg.sv =====
// ----------------------------------------------------------------------------
// Chord label mode smoother package
// Shared widths, parameter defaults and the token that travels along the
// row of label count cells.
// ----------------------------------------------------------------------------
package clms_pkg;

   localparam int LABEL_W = 5;
   localparam int CFG_W   = 5;

   localparam int DEF_MAX_HALF_WINDOW = 16;
   localparam int DEF_NUM_LABELS      = 24;
   localparam int DEF_FRAME_BITS      = 20;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

   typedef struct packed {
      logic               valid;
      logic               add_valid;
      logic [LABEL_W-1:0] add_label;
      logic               rem_valid;
      logic [LABEL_W-1:0] rem_label;
      logic               emit;
      logic               close;
   } token_type;

endpackage

// ===== rtl/clms_window_line.sv =====
// ----------------------------------------------------------------------------
// Chord label mode smoother window line
// A row of label cells that shifts by one place per push. Frames enter at a
// place chosen by the track's half window, so the frame that leaves the
// window always drops off the far end of the row.
// ----------------------------------------------------------------------------
module clms_window_line #(
   parameter int  MAX_HALF_WINDOW = clms_pkg::DEF_MAX_HALF_WINDOW,
   localparam int HW_W            = $clog2(MAX_HALF_WINDOW + 1),
   localparam int LW              = clms_pkg::LABEL_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic            push_valid,
   input  logic [LW-1:0]   push_label,
   input  logic [HW_W-1:0] window,
   output logic            rem_valid,
   output logic [LW-1:0]   rem_label,
   output logic            centre_valid
);

   localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;

   logic [DEPTH-1:0]         valid_ff, valid_in;
   logic [DEPTH-1:0][LW-1:0] label_ff, label_in;

   always_comb begin
      int entry;
      int centre;
      entry        = 2 * MAX_HALF_WINDOW - 2 * int'(window);
      centre       = 2 * MAX_HALF_WINDOW - int'(window) - 1;
      valid_in     = valid_ff;
      label_in     = label_ff;
      centre_valid = 1'b0;
      if (push) begin
         if (entry == 0) begin
            valid_in[0] = push_valid;
            label_in[0] = push_label;
         end else begin
            valid_in[0] = 1'b0;
         end
      end
      if (centre == 0) begin
         centre_valid = valid_ff[0];
      end
      for (int k = 1; k < DEPTH; k++) begin
         if (push) begin
            if (k == entry) begin
               valid_in[k] = push_valid;
               label_in[k] = push_label;
            end else begin
               valid_in[k] = valid_ff[k-1];
               label_in[k] = label_ff[k-1];
            end
         end
         if (k == centre) begin
            centre_valid = valid_ff[k];
         end
      end
   end

   assign rem_valid = valid_ff[DEPTH-1];
   assign rem_label = label_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
   end

endmodule

// ===== rtl/clms_count_cell.sv =====
// ----------------------------------------------------------------------------
// Chord label mode smoother count cell
// Holds the window count of one label. A passing token updates the count
// and carries the running maximum on to the next cell.
// ----------------------------------------------------------------------------
module clms_count_cell #(
   parameter int  LABEL_ID = 0,
   parameter int  CNT_W    = 6,
   localparam int LW       = clms_pkg::LABEL_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  clms_pkg::token_type  tok_in,
   input  logic [LW-1:0]        best_label_in,
   input  logic [CNT_W-1:0]     best_count_in,
   output clms_pkg::token_type  tok_out,
   output logic [LW-1:0]        best_label_out,
   output logic [CNT_W-1:0]     best_count_out
);

   localparam logic [LW-1:0] MY_LABEL = LW'(LABEL_ID);

   logic [CNT_W-1:0]    count_ff, count_in, count_upd;
   logic                hit_add, hit_rem, better;
   clms_pkg::token_type tok_ff;
   logic [LW-1:0]       best_label_ff, best_label_in2;
   logic [CNT_W-1:0]    best_count_ff, best_count_in2;

   always_comb begin
      hit_add   = tok_in.valid && tok_in.add_valid && (tok_in.add_label == MY_LABEL);
      hit_rem   = tok_in.valid && tok_in.rem_valid && (tok_in.rem_label == MY_LABEL);
      count_upd = count_ff + CNT_W'(hit_add) - CNT_W'(hit_rem);
      count_in  = tok_in.valid ? count_upd : count_ff;
      better    = count_upd > best_count_in;
      best_label_in2 = better ? MY_LABEL : best_label_in;
      best_count_in2 = better ? count_upd : best_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tok_ff   <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         best_label_ff <= best_label_in2;
         best_count_ff <= best_count_in2;
      end
   end

   assign tok_out        = tok_ff;
   assign best_label_out = best_label_ff;
   assign best_count_out = best_count_ff;

endmodule

// ===== rtl/clms_segmenter.sv =====
// ----------------------------------------------------------------------------
// Chord label mode smoother segmenter
// Merges the smoothed labels leaving the count cells into runs and holds
// the result register of the output channel.
// ----------------------------------------------------------------------------
module clms_segmenter #(
   parameter int  FRAME_BITS = clms_pkg::DEF_FRAME_BITS,
   localparam int LW         = clms_pkg::LABEL_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  clms_pkg::token_type tok,
   input  logic [LW-1:0]       best_label,
   output logic                rsp_valid,
   output logic [LW-1:0]       seg_label,
   output logic [FRAME_BITS-1:0] seg_start,
   output logic [FRAME_BITS:0] seg_end,
   output logic                last_segment
);

   logic                  run_open_ff, run_open_in;
   logic [LW-1:0]         run_label_ff, run_label_in;
   logic [FRAME_BITS-1:0] run_start_ff, run_start_in;
   logic [FRAME_BITS:0]   smoothed_ff, smoothed_in;
   logic                  out_valid_ff, out_valid_in;
   logic [LW-1:0]         out_label_ff, out_label_in;
   logic [FRAME_BITS-1:0] out_start_ff, out_start_in;
   logic [FRAME_BITS:0]   out_end_ff, out_end_in;
   logic                  out_last_ff, out_last_in;

   always_comb begin
      run_open_in  = run_open_ff;
      run_label_in = run_label_ff;
      run_start_in = run_start_ff;
      smoothed_in  = smoothed_ff;
      out_valid_in = out_valid_ff;
      out_label_in = out_label_ff;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (tok.valid && tok.close) begin
            if (run_open_ff) begin
               out_valid_in = 1'b1;
               out_label_in = run_label_ff;
               out_start_in = run_start_ff;
               out_end_in   = smoothed_ff;
               out_last_in  = 1'b1;
            end
            run_open_in  = 1'b0;
            run_label_in = '0;
            run_start_in = '0;
            smoothed_in  = '0;
         end else if (tok.valid && tok.emit) begin
            smoothed_in = smoothed_ff + 1'b1;
            if (!run_open_ff) begin
               run_open_in  = 1'b1;
               run_label_in = best_label;
               run_start_in = smoothed_ff[FRAME_BITS-1:0];
            end else if (best_label != run_label_ff) begin
               out_valid_in = 1'b1;
               out_label_in = run_label_ff;
               out_start_in = run_start_ff;
               out_end_in   = smoothed_ff;
               out_last_in  = 1'b0;
               run_label_in = best_label;
               run_start_in = smoothed_ff[FRAME_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         run_label_ff <= '0;
         run_start_ff <= '0;
         smoothed_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_open_ff  <= run_open_in;
         run_label_ff <= run_label_in;
         run_start_ff <= run_start_in;
         smoothed_ff  <= smoothed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_label_ff <= out_label_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign seg_label    = out_label_ff;
   assign seg_start    = out_start_ff;
   assign seg_end      = out_end_ff;
   assign last_segment = out_last_ff;

endmodule

// ===== rtl/chord_label_mode_smoother.sv =====
// ----------------------------------------------------------------------------
// Chord label mode smoother
// Replaces each frame's chord label by the most frequent label of a centred
// window and merges the smoothed labels into segments.
// Throughput: one frame per cycle while the output is not stalled; a final
// frame then holds the input off while the window line is flushed.
// Output path: the push that ends a segment sends its token through the row
// of label count cells that the maximum search walks, then the result register.
// Reset: synchronous; clears all counts, the track and sets the half window
// to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module chord_label_mode_smoother #(
   parameter int  MAX_HALF_WINDOW = clms_pkg::DEF_MAX_HALF_WINDOW,
   parameter int  NUM_LABELS      = clms_pkg::DEF_NUM_LABELS,
   parameter int  FRAME_BITS      = clms_pkg::DEF_FRAME_BITS,
   localparam int LW              = clms_pkg::LABEL_W,
   localparam int REQ_DATA_W      = ((LW + 7) / 8) * 8,
   localparam int RSP_DATA_W      = ((LW + 2 * FRAME_BITS + 1 + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_W-1:0]     req_tdata,   // label
   input  logic                      req_tlast,   // last_frame
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,   // seg_label, seg_start, seg_end
   output logic                      rsp_tlast,   // last_segment
   input  logic                      csr_wr_en,
   input  logic [clms_pkg::CFG_W-1:0] csr_wr_data // half_window
);

   localparam int HW_W  = $clog2(MAX_HALF_WINDOW + 1);
   localparam int CNT_W = $clog2(2 * MAX_HALF_WINDOW + 2);

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } state_type;

   state_type                  state_ff, state_in;
   logic [clms_pkg::CFG_W-1:0] half_window_ff;
   logic [HW_W-1:0]            track_w_ff, track_w_in;
   logic [HW_W:0]              flush_cnt_ff, flush_cnt_in;
   logic [FRAME_BITS:0]        seen_ff, seen_in;

   logic                advance, accept, push, push_real, close;
   logic [HW_W-1:0]     eff_window, w_push;
   logic [LW-1:0]       label_clamped;
   logic                line_rem_valid, line_centre_valid;
   logic [LW-1:0]       line_rem_label;
   clms_pkg::token_type tok_in;

   clms_pkg::token_type tok_chain        [NUM_LABELS+1];
   logic [LW-1:0]       best_label_chain [NUM_LABELS+1];
   logic [CNT_W-1:0]    best_count_chain [NUM_LABELS+1];

   logic                  seg_valid, seg_last;
   logic [LW-1:0]         seg_label;
   logic [FRAME_BITS-1:0] seg_start;
   logic [FRAME_BITS:0]   seg_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= clms_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         half_window_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (half_window_ff == '0) begin
         eff_window = HW_W'(1);
      end else if (int'(half_window_ff) > MAX_HALF_WINDOW) begin
         eff_window = HW_W'(MAX_HALF_WINDOW);
      end else begin
         eff_window = HW_W'(half_window_ff);
      end
      if (int'(req_tdata[LW-1:0]) >= NUM_LABELS) begin
         label_clamped = LW'(NUM_LABELS - 1);
      end else begin
         label_clamped = req_tdata[LW-1:0];
      end
   end

   assign advance    = !seg_valid || rsp_tready;
   assign req_tready = advance && (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign w_push     = (state_ff == ST_IDLE && seen_ff == '0) ? eff_window : track_w_ff;

   always_comb begin
      state_in     = state_ff;
      track_w_in   = track_w_ff;
      flush_cnt_in = flush_cnt_ff;
      seen_in      = seen_ff;
      push         = 1'b0;
      push_real    = 1'b0;
      close        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               track_w_in = w_push;
               if (!seen_ff[FRAME_BITS]) begin
                  push      = 1'b1;
                  push_real = 1'b1;
                  seen_in   = seen_ff + 1'b1;
               end
               if (req_tlast) begin
                  seen_in      = '0;
                  flush_cnt_in = {w_push, 1'b1};
                  state_in     = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (advance) begin
               push         = 1'b1;
               flush_cnt_in = flush_cnt_ff - 1'b1;
               if (flush_cnt_ff == (HW_W + 1)'(1)) begin
                  close    = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         track_w_ff   <= HW_W'(1);
         flush_cnt_ff <= '0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         track_w_ff   <= track_w_in;
         flush_cnt_ff <= flush_cnt_in;
         seen_ff      <= seen_in;
      end
   end

   clms_window_line #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
   ) u_line (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_valid   (push_real),
      .push_label   (label_clamped),
      .window       (w_push),
      .rem_valid    (line_rem_valid),
      .rem_label    (line_rem_label),
      .centre_valid (line_centre_valid)
   );

   always_comb begin
      tok_in.valid     = push;
      tok_in.add_valid = push_real;
      tok_in.add_label = label_clamped;
      tok_in.rem_valid = push && line_rem_valid;
      tok_in.rem_label = line_rem_label;
      tok_in.emit      = push && line_centre_valid;
      tok_in.close     = close;
   end

   assign tok_chain[0]        = tok_in;
   assign best_label_chain[0] = '0;
   assign best_count_chain[0] = '0;

   for (genvar g = 0; g < NUM_LABELS; g++) begin : g_cell
      clms_count_cell #(
         .LABEL_ID (g),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .tok_in         (tok_chain[g]),
         .best_label_in  (best_label_chain[g]),
         .best_count_in  (best_count_chain[g]),
         .tok_out        (tok_chain[g+1]),
         .best_label_out (best_label_chain[g+1]),
         .best_count_out (best_count_chain[g+1])
      );
   end

   clms_segmenter #(
      .FRAME_BITS (FRAME_BITS)
   ) u_seg (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .tok          (tok_chain[NUM_LABELS]),
      .best_label   (best_label_chain[NUM_LABELS]),
      .rsp_valid    (seg_valid),
      .seg_label    (seg_label),
      .seg_start    (seg_start),
      .seg_end      (seg_end),
      .last_segment (seg_last)
   );

   assign rsp_tvalid = seg_valid;
   assign rsp_tdata  = RSP_DATA_W'({seg_end, seg_start, seg_label});
   assign rsp_tlast  = seg_last;

endmodule
